// File: design/swpd_pkg.sv
// ----------------------------------------------------------------------------
// swpd_pkg: shared definitions for the sliding-window strict peak detector
//
// Sizes, derived widths and the packed request and result types used by
// the top level and the window cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swpd_pkg;

  // Largest radius the window supports; larger configured values saturate.
  localparam int MAX_RADIUS  = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int INDEX_BITS  = 16;
  localparam int CFG_BITS    = 4;

  // Derived sizes.
  localparam int WIN_DEPTH    = 2 * MAX_RADIUS + 1;
  localparam int WIN_IDX_BITS = $clog2(WIN_DEPTH);
  localparam int FILL_BITS    = $clog2(WIN_DEPTH + 1);
  localparam int RADIUS_BITS  = $clog2(MAX_RADIUS + 1);

  localparam logic [CFG_BITS-1:0] RADIUS_RESET = CFG_BITS'(1);

  // One incoming request.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          start_req;
  } req_t;

  // One result.
  typedef struct packed {
    logic                          judged;
    logic                          is_peak;
    logic signed [SAMPLE_BITS-1:0] center_value;
    logic [INDEX_BITS-1:0]         center_index;
  } res_t;

endpackage

// File: design/swpd_cell.sv
// ----------------------------------------------------------------------------
// swpd_cell: one window position
//
// Holds one sample, hands it to the next cell on every shift, and tells
// whether the window centre strictly exceeds the sample it holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swpd_cell (
  input  logic                                   clk,
  input  logic                                   shift_en,
  input  logic signed [swpd_pkg::SAMPLE_BITS-1:0] din,
  input  logic signed [swpd_pkg::SAMPLE_BITS-1:0] centre,
  input  logic                                   skip,
  output logic signed [swpd_pkg::SAMPLE_BITS-1:0] held,
  output logic                                   pass
);

  // Sample storage; it moves one place down the row on each accepted request.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      held <= din;
    end
  end

  // A cell outside the window, or the centre cell itself, never vetoes a peak.
  assign pass = skip || (centre > held);

endmodule

// File: design/sliding_window_strict_peak_detect_top.sv
// ----------------------------------------------------------------------------
// sliding_window_strict_peak_detect_top: strict local-maximum peak detector
//
// Takes one signed sample per request and returns one result per request.
// The last 2R+1 samples sit in a row of cells that shift on every accepted
// request; once the row holds 2R+1 samples of the current sequence, the
// sample R places back is judged a peak when it is strictly greater than
// every other sample in the window. A request is accepted every cycle as
// long as the result path keeps moving: the window shifts on acceptance,
// and then all cells compare against the centre in parallel and the result
// lands in the output register once that register is free, so a request
// can enter while the one before it is judged. The radius register is
// written through its own port (always ready) and must only change while
// no request is in flight; values above the maximum radius saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_strict_peak_detect_top (
  input  logic                              clk,
  input  logic                              rst,
  // Request channel.
  input  logic                              req_valid,
  output logic                              req_stall,
  input  swpd_pkg::req_t                    req_data,
  // Result channel.
  output logic                              res_valid,
  input  logic                              res_stall,
  output swpd_pkg::res_t                    res_data,
  // Radius register write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [swpd_pkg::CFG_BITS-1:0]     cfg_data
);

  // Control and pending-judgement registers.
  logic [swpd_pkg::CFG_BITS-1:0]     radius;
  logic [swpd_pkg::FILL_BITS-1:0]    fill;
  logic [swpd_pkg::FILL_BITS-1:0]    fill_next;
  logic [swpd_pkg::INDEX_BITS-1:0]   index;
  logic [swpd_pkg::INDEX_BITS-1:0]   index_next;
  logic                              pend;
  logic                              pend_judged;
  logic [swpd_pkg::RADIUS_BITS-1:0]  pend_r;
  logic [swpd_pkg::FILL_BITS-1:0]    pend_span;
  logic [swpd_pkg::INDEX_BITS-1:0]   pend_idx;

  logic                              req_take;
  logic                              pend_move;
  logic [swpd_pkg::RADIUS_BITS-1:0]  r_sat;
  logic [swpd_pkg::FILL_BITS-1:0]    span;
  logic [swpd_pkg::FILL_BITS-1:0]    fill_base;
  logic [swpd_pkg::INDEX_BITS-1:0]   index_base;

  logic signed [swpd_pkg::SAMPLE_BITS-1:0] win  [swpd_pkg::WIN_DEPTH];
  logic                                    pass [swpd_pkg::WIN_DEPTH];
  logic [swpd_pkg::WIN_DEPTH-1:0]          pass_vec;
  logic signed [swpd_pkg::SAMPLE_BITS-1:0] centre;
  swpd_pkg::res_t                          res_next;

  // Handshakes: the pending judgement moves out unless the output is held.
  assign pend_move = !(res_valid && res_stall);
  assign req_stall = pend && !pend_move;
  assign req_take  = req_valid && !req_stall;
  assign cfg_ready = 1'b1;

  // Radius register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= swpd_pkg::RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radius <= cfg_data;
    end
  end

  // Effective radius and window span.
  always_comb begin
    if (int'(radius) > swpd_pkg::MAX_RADIUS) begin
      r_sat = swpd_pkg::RADIUS_BITS'(swpd_pkg::MAX_RADIUS);
    end else begin
      r_sat = swpd_pkg::RADIUS_BITS'(radius);
    end
    span = swpd_pkg::FILL_BITS'({r_sat, 1'b1});
  end

  // Fill count and sample index; a start marker clears both first.
  always_comb begin
    fill_base  = req_data.start_req ? '0 : fill;
    index_base = req_data.start_req ? '0 : index;
    if (int'(fill_base) < swpd_pkg::WIN_DEPTH) begin
      fill_next = fill_base + swpd_pkg::FILL_BITS'(1);
    end else begin
      fill_next = fill_base;
    end
    index_next = index_base + swpd_pkg::INDEX_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      index <= '0;
    end else if (req_take) begin
      fill  <= fill_next;
      index <= index_next;
    end
  end

  // Pending judgement: what the next compare cycle needs to know.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (req_take) begin
      pend <= 1'b1;
    end else if (pend_move) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      pend_judged <= (fill_next >= span);
      pend_r      <= r_sat;
      pend_span   <= span;
      pend_idx    <= index_base - swpd_pkg::INDEX_BITS'(r_sat);
    end
  end

  // Window centre for the pending judgement.
  assign centre = win[swpd_pkg::WIN_IDX_BITS'(pend_r)];

  // Row of cells; cell zero takes the new sample, the rest take their neighbor.
  for (genvar k = 0; k < swpd_pkg::WIN_DEPTH; k++) begin : g_cell
    logic signed [swpd_pkg::SAMPLE_BITS-1:0] cell_in;
    logic                                    cell_skip;

    if (k == 0) begin : g_head
      assign cell_in = req_data.sample;
    end else begin : g_body
      assign cell_in = win[k-1];
    end

    assign cell_skip = (swpd_pkg::RADIUS_BITS'(k) == pend_r && k <= swpd_pkg::MAX_RADIUS)
                    || (swpd_pkg::FILL_BITS'(k) >= pend_span);

    swpd_cell u_cell (
      .clk      (clk),
      .shift_en (req_take),
      .din      (cell_in),
      .centre   (centre),
      .skip     (cell_skip),
      .held     (win[k]),
      .pass     (pass[k])
    );

    assign pass_vec[k] = pass[k];
  end

  // Result assembly; unjudged results carry zero fields.
  always_comb begin
    res_next = '0;
    if (pend_judged) begin
      res_next.judged       = 1'b1;
      res_next.is_peak      = &pass_vec;
      res_next.center_value = centre;
      res_next.center_index = pend_idx;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pend_move) begin
      res_valid <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move && pend) begin
      res_data <= res_next;
    end
  end

endmodule
